// ===== hdl/modular_inverse_ext_euclid_core_defines.svh =====
// ---------------------------------------------------------------------------
// modular inverse core - assertion macros
// Concurrent assertion wrappers, used by the core's datapath.
// ---------------------------------------------------------------------------
`ifndef MODULAR_INVERSE_EXT_EUCLID_CORE_DEFINES_SVH
`define MODULAR_INVERSE_EXT_EUCLID_CORE_DEFINES_SVH

// clocked assertion, disabled while reset is asserted
`define MIE_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// clocked assertion that also holds through reset
`define MIE_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

// ===== hdl/mie_pkg.sv =====
// ---------------------------------------------------------------------------
// mie_pkg
// Microcode types, control word layout and the sequencer program.
// ---------------------------------------------------------------------------
`default_nettype none

package mie_pkg;

  // program counter width, the program has eight steps
  localparam int unsigned PC_W = 3;

  // modulus after reset
  localparam logic [63:0] MOD_RESET = 64'd1000000007;

  // datapath operations
  typedef enum logic [2:0] {
    OP_LOAD     = 3'd0,
    OP_NOP      = 3'd1,
    OP_DIV_INIT = 3'd2,
    OP_DIV_STEP = 3'd3,
    OP_UPDATE   = 3'd4,
    OP_FOLD_NEG = 3'd5,
    OP_FOLD_HI  = 3'd6,
    OP_EMIT     = 3'd7
  } op_e;

  // jump conditions
  typedef enum logic [2:0] {
    COND_NEVER    = 3'd0,
    COND_NO_REQ   = 3'd1,
    COND_B_ZERO   = 3'd2,
    COND_DIV_MORE = 3'd3,
    COND_OUT_FULL = 3'd4,
    COND_ALWAYS   = 3'd5
  } cond_e;

  // one control word
  typedef struct packed {
    op_e             op;
    cond_e           cond;
    logic [PC_W-1:0] target;
  } ctrl_t;

  // datapath flags seen by the sequencer
  typedef struct packed {
    logic req;
    logic b_zero;
    logic div_more;
    logic out_full;
  } status_t;

  // program addresses
  localparam logic [PC_W-1:0] PC_WAIT   = 3'd0;
  localparam logic [PC_W-1:0] PC_TEST   = 3'd1;
  localparam logic [PC_W-1:0] PC_INIT   = 3'd2;
  localparam logic [PC_W-1:0] PC_DIV    = 3'd3;
  localparam logic [PC_W-1:0] PC_UPDATE = 3'd4;
  localparam logic [PC_W-1:0] PC_FNEG   = 3'd5;
  localparam logic [PC_W-1:0] PC_FHI    = 3'd6;
  localparam logic [PC_W-1:0] PC_EMIT   = 3'd7;

  // microcode rom; a step that does not jump falls through to pc + 1,
  // and the emit step falls through to the wait step by wrap-around
  function automatic ctrl_t ucode(input logic [PC_W-1:0] pc);
    ctrl_t w;
    unique case (pc)
      PC_WAIT:   w = '{op: OP_LOAD,     cond: COND_NO_REQ,   target: PC_WAIT};
      PC_TEST:   w = '{op: OP_NOP,      cond: COND_B_ZERO,   target: PC_FNEG};
      PC_INIT:   w = '{op: OP_DIV_INIT, cond: COND_NEVER,    target: PC_WAIT};
      PC_DIV:    w = '{op: OP_DIV_STEP, cond: COND_DIV_MORE, target: PC_DIV};
      PC_UPDATE: w = '{op: OP_UPDATE,   cond: COND_ALWAYS,   target: PC_TEST};
      PC_FNEG:   w = '{op: OP_FOLD_NEG, cond: COND_NEVER,    target: PC_WAIT};
      PC_FHI:    w = '{op: OP_FOLD_HI,  cond: COND_NEVER,    target: PC_WAIT};
      PC_EMIT:   w = '{op: OP_EMIT,     cond: COND_OUT_FULL, target: PC_EMIT};
      default:   w = '{op: OP_LOAD,     cond: COND_NO_REQ,   target: PC_WAIT};
    endcase
    return w;
  endfunction

endpackage

`default_nettype wire

// ===== hdl/mie_sequencer.sv =====
// ---------------------------------------------------------------------------
// mie_sequencer
// Step counter over the microcode rom with conditional jumps.
// ---------------------------------------------------------------------------
`default_nettype none

module mie_sequencer (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire mie_pkg::status_t status_i,
  output mie_pkg::ctrl_t        ctrl_o
);
  import mie_pkg::*;

  logic [PC_W-1:0] pc_q, pc_d;
  ctrl_t           word;
  logic            take;

  // fetch the current control word
  assign word   = ucode(pc_q);
  assign ctrl_o = word;

  // evaluate the jump condition
  always_comb begin
    unique case (word.cond)
      COND_NEVER:    take = 1'b0;
      COND_NO_REQ:   take = !status_i.req;
      COND_B_ZERO:   take = status_i.b_zero;
      COND_DIV_MORE: take = status_i.div_more;
      COND_OUT_FULL: take = status_i.out_full;
      COND_ALWAYS:   take = 1'b1;
      default:       take = 1'b0;
    endcase
  end

  // next step
  assign pc_d = take ? word.target : pc_q + PC_W'(1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q <= PC_WAIT;
    end else begin
      pc_q <= pc_d;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/mie_datapath.sv =====
// ---------------------------------------------------------------------------
// mie_datapath
// Remainder and coefficient registers, bit-serial divider, fold and output.
// ---------------------------------------------------------------------------
`default_nettype none
`include "modular_inverse_ext_euclid_core_defines.svh"

module mie_datapath #(
  parameter int unsigned DATA_WIDTH = 31
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire mie_pkg::ctrl_t        ctrl_i,
  output mie_pkg::status_t           status_o,
  input  wire logic                  in_valid_i,
  input  wire logic [DATA_WIDTH-1:0] value_i,
  input  wire logic                  cfg_we_i,
  input  wire logic [DATA_WIDTH-1:0] cfg_data_i,
  input  wire logic                  out_stall_i,
  output logic                       out_valid_o,
  output logic [DATA_WIDTH-1:0]      inverse_o,
  output logic [DATA_WIDTH-1:0]      gcd_o
);
  import mie_pkg::*;

  // coefficients stay within plus or minus the modulus, two guard bits
  localparam int unsigned CW    = DATA_WIDTH + 2;
  localparam int unsigned CNT_W = $clog2(DATA_WIDTH);

  logic [DATA_WIDTH-1:0]   modulus_q;
  logic [DATA_WIDTH-1:0]   a_q, a_d, b_q, b_d;
  logic signed [CW-1:0]    u_q, u_d, v_q, v_d;
  logic [DATA_WIDTH-1:0]   dq_q, dq_d;
  logic [DATA_WIDTH-1:0]   rem_q, rem_d;
  logic signed [CW-1:0]    acc_q, acc_d;
  logic [CNT_W-1:0]        cnt_q, cnt_d;
  logic                    out_valid_q, out_valid_d;
  logic [DATA_WIDTH-1:0]   inv_q, gcd_q;
  logic                    out_full;
  logic                    emit_load;
  logic [DATA_WIDTH:0]     rem_sh;
  logic                    q_bit;
  logic signed [CW-1:0]    mod_ext;

  assign mod_ext   = signed'({{(CW-DATA_WIDTH){1'b0}}, modulus_q});
  assign out_full  = out_valid_q && out_stall_i;
  assign emit_load = (ctrl_i.op == OP_EMIT) && !out_full;

  // restoring divider step: shift in the next dividend bit
  assign rem_sh = {rem_q, dq_q[DATA_WIDTH-1]};
  assign q_bit  = rem_sh >= {1'b0, b_q};

  // status toward the sequencer
  assign status_o = '{req:      in_valid_i,
                      b_zero:   (b_q == '0),
                      div_more: (cnt_q != '0),
                      out_full: out_full};

  // configuration register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      modulus_q <= DATA_WIDTH'(MOD_RESET);
    end else if (cfg_we_i) begin
      modulus_q <= cfg_data_i;
    end
  end

  // datapath operations
  always_comb begin
    a_d   = a_q;
    b_d   = b_q;
    u_d   = u_q;
    v_d   = v_q;
    dq_d  = dq_q;
    rem_d = rem_q;
    acc_d = acc_q;
    cnt_d = cnt_q;
    unique case (ctrl_i.op)
      OP_LOAD: begin
        if (in_valid_i) begin
          a_d = value_i;
          b_d = modulus_q;
          u_d = CW'(1);
          v_d = '0;
        end
      end
      OP_DIV_INIT: begin
        dq_d  = a_q;
        rem_d = '0;
        acc_d = '0;
        cnt_d = CNT_W'(DATA_WIDTH - 1);
      end
      OP_DIV_STEP: begin
        // quotient bits come msb first, so q*v builds up by shift and add
        rem_d = q_bit ? DATA_WIDTH'(rem_sh - {1'b0, b_q}) : rem_sh[DATA_WIDTH-1:0];
        dq_d  = {dq_q[DATA_WIDTH-2:0], 1'b0};
        acc_d = (acc_q <<< 1) + (q_bit ? v_q : '0);
        cnt_d = cnt_q - CNT_W'(1);
      end
      OP_UPDATE: begin
        a_d = b_q;
        b_d = rem_q;
        u_d = v_q;
        v_d = u_q - acc_q;
      end
      OP_FOLD_NEG: begin
        // zero modulus gives a zero inverse
        if (modulus_q == '0) begin
          u_d = '0;
        end else if (u_q[CW-1]) begin
          u_d = u_q + mod_ext;
        end
      end
      OP_FOLD_HI: begin
        if (u_q >= mod_ext) begin
          u_d = u_q - mod_ext;
        end
      end
      OP_NOP, OP_EMIT: begin
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    a_q   <= a_d;
    b_q   <= b_d;
    u_q   <= u_d;
    v_q   <= v_d;
    dq_q  <= dq_d;
    rem_q <= rem_d;
    acc_q <= acc_d;
    cnt_q <= cnt_d;
  end

  // output register, refilled when the previous result has left
  always_comb begin
    out_valid_d = out_valid_q;
    if (emit_load) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit_load) begin
      inv_q <= u_q[DATA_WIDTH-1:0];
      gcd_q <= a_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign inverse_o   = inv_q;
  assign gcd_o       = gcd_q;

  // partial remainder of the divider stays below the divisor
  `MIE_ASSERT(a_rem_below_div, (ctrl_i.op == OP_DIV_STEP) |-> (rem_q < b_q), "divider remainder not below divisor")
  // folding starts only once the remainder sequence has ended
  `MIE_ASSERT(a_fold_after_end, (ctrl_i.op == OP_FOLD_NEG) |-> (b_q == '0), "fold entered with nonzero remainder")
  // a result taken with no new one behind it empties the output register
  `MIE_ASSERT(a_out_drain, (out_valid_q && !out_stall_i && !emit_load) |=> !out_valid_q, "output register did not drain")

endmodule

`default_nettype wire

// ===== hdl/modular_inverse_ext_euclid_core.sv =====
// ---------------------------------------------------------------------------
// modular_inverse_ext_euclid_core
// Modular inverse and gcd by the extended Euclidean algorithm.
// ---------------------------------------------------------------------------
// Usage:
//   Input channel: value_i with in_valid_i; a request is taken when
//   in_valid_i is high and in_stall_o is low. in_stall_o is low only while
//   the sequencer sits in its wait step.
//   Output channel: inverse_o and gcd_o with out_valid_o; a result leaves
//   when out_valid_o is high and out_stall_i is low.
//   Configuration: cfg_we_i writes cfg_data_i into the modulus register;
//   write only while no request is in flight.
// Run: from accept to result the core performs K Euclid steps (about 46
//   at most for 31-bit operands). Each step is a test, a divider setup,
//   a bit-serial restoring divide over DATA_WIDTH quotient bits and a
//   register update; the divider loop takes most of the run. A fold of
//   the coefficient into range and the emit step follow the last step.
// Requests: one request in flight at a time, so the next request is taken
//   only once the previous run has left its emit step; results drain freely.
// Stall: a finished result waits in the output register; the next request
//   is accepted meanwhile and its run holds in the emit step until the
//   register frees up.
// Reset: sequencer returns to the wait step, output register empties and
//   the modulus returns to 1000000007.
// ---------------------------------------------------------------------------
`default_nettype none

module modular_inverse_ext_euclid_core #(
  parameter int unsigned DATA_WIDTH = 31
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  in_valid_i,
  output logic                       in_stall_o,
  input  wire logic [DATA_WIDTH-1:0] value_i,
  input  wire logic                  cfg_we_i,
  input  wire logic [DATA_WIDTH-1:0] cfg_data_i,
  output logic                       out_valid_o,
  input  wire logic                  out_stall_i,
  output logic [DATA_WIDTH-1:0]      inverse_o,
  output logic [DATA_WIDTH-1:0]      gcd_o
);
  import mie_pkg::*;

  ctrl_t   ctrl;
  status_t status;

  // program sequencer
  mie_sequencer u_seq (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .status_i (status),
    .ctrl_o   (ctrl)
  );

  // arithmetic datapath
  mie_datapath #(
    .DATA_WIDTH (DATA_WIDTH)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctrl_i      (ctrl),
    .status_o    (status),
    .in_valid_i  (in_valid_i),
    .value_i     (value_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_data_i  (cfg_data_i),
    .out_stall_i (out_stall_i),
    .out_valid_o (out_valid_o),
    .inverse_o   (inverse_o),
    .gcd_o       (gcd_o)
  );

  // requests are taken only in the wait step
  assign in_stall_o = (ctrl.op != OP_LOAD);

endmodule

`default_nettype wire

// ===== sim/modular_inverse_ext_euclid_core_tb.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// modular_inverse_ext_euclid_core_tb
// Self-checking bench for the modular inverse core. Requests are queued by a
// sequence process, driven by a clocked driver and checked by a clocked
// monitor against an extended Euclid predictor, over several moduli and
// several patterns of sender idling and receiver stalling.
// ---------------------------------------------------------------------------

module modular_inverse_ext_euclid_core_tb;

  localparam int W = 31;
  localparam logic [W-1:0] VAL_MAX = {W{1'b1}};
  // timeout limit, with a wide margin over the slowest requests
  localparam int unsigned CYCLE_LIMIT = 3000000;
  localparam int unsigned HOLD_CYCLES = 3000;
  localparam int unsigned DRAIN_CYCLES = 1700;
  localparam int unsigned RANDOM_PHASES = 8;
  localparam int unsigned PHASE_REQUESTS = 45;

  // expected result of one request
  typedef struct {
    logic [W-1:0] operand;
    logic [W-1:0] modulus;
    logic [W-1:0] inverse;
    logic [W-1:0] gcd;
  } inv_result_t;

  logic         clk_i;
  logic         rst_ni = 1'b0;
  logic         in_valid_i = 1'b0;
  logic         in_stall_o;
  logic [W-1:0] value_i = '0;
  logic         cfg_we_i = 1'b0;
  logic [W-1:0] cfg_data_i = '0;
  logic         out_valid_o;
  logic         out_stall_i = 1'b0;
  logic [W-1:0] inverse_o;
  logic [W-1:0] gcd_o;

  logic [W-1:0] value_q[$];
  inv_result_t  inverse_due_q[$];
  inv_result_t  seen_due;
  logic [W-1:0] modulus_model = mie_pkg::MOD_RESET[W-1:0];
  int unsigned  sender_idle_pct = 0;
  int unsigned  recv_stall_pct = 0;
  logic         hold_start = 1'b0;
  logic         recv_hold = 1'b0;
  logic         keep_offer;
  int unsigned  mismatch_count = 0;
  int unsigned  cycle_count = 0;
  logic [W-1:0] phase_modulus;

  modular_inverse_ext_euclid_core #(
    .DATA_WIDTH(W)
  ) i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .value_i    (value_i),
    .cfg_we_i   (cfg_we_i),
    .cfg_data_i (cfg_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .inverse_o  (inverse_o),
    .gcd_o      (gcd_o)
  );

  // extended euclid on (operand, modulus), coefficient folded into 0..m-1
  function automatic inv_result_t predict_inverse(input logic [W-1:0] operand,
                                                  input logic [W-1:0] m);
    longint unsigned rem_hi, rem_lo, quot, rem_next;
    longint          coef_hi, coef_lo, coef_next, folded;
    inv_result_t     res;
    rem_hi = operand;
    rem_lo = m;
    coef_hi = 1;
    coef_lo = 0;
    while (rem_lo != 0) begin
      quot = rem_hi / rem_lo;
      rem_next = rem_hi - quot * rem_lo;
      coef_next = (coef_lo == 0) ? coef_hi : coef_hi - longint'(quot) * coef_lo;
      rem_hi = rem_lo;
      rem_lo = rem_next;
      coef_hi = coef_lo;
      coef_lo = coef_next;
    end
    if (m == 0) begin
      folded = 0;
    end else begin
      folded = coef_hi % longint'(m);
      if (folded < 0) folded = folded + longint'(m);
    end
    res.operand = operand;
    res.modulus = m;
    res.inverse = W'(folded);
    res.gcd = W'(rem_hi);
    return res;
  endfunction

  // random modulus per phase, always at least 2
  function automatic logic [W-1:0] pick_modulus(input int unsigned sel);
    logic [W-1:0] m;
    case (sel % 6)
      0: m = VAL_MAX;
      2: m = W'($urandom_range(2, 1000));
      3: m = {1'b1, {(W-1){1'b0}}};
      // product of small primes gives many non-invertible operands
      4: m = W'(30030 * $urandom_range(1, 60000));
      default: m = W'($urandom);
    endcase
    if (m < 2) m = 2;
    return m;
  endfunction

  // operand mix: mostly full-width, some small, below or near multiples of m
  function automatic logic [W-1:0] pick_value(input logic [W-1:0] m);
    int unsigned kind;
    kind = $urandom_range(0, 9);
    if (kind < 6) return W'($urandom);
    if (kind == 6) return W'($urandom_range(0, 255));
    if (kind == 7) return W'($urandom_range(0, m - 1));
    if (kind == 8) return W'(m * $urandom_range(0, 3) + $urandom_range(0, 2));
    return W'(m / $urandom_range(2, 7) * $urandom_range(1, 3));
  endfunction

  task automatic report_mismatch(input string msg);
    $display("mismatch at cycle %0d: %s", cycle_count, msg);
    mismatch_count++;
  endtask

  // modulus write, only while the core is idle
  task automatic write_modulus(input logic [W-1:0] m);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_data_i <= m;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    modulus_model = m;
    @(negedge clk_i);
  endtask

  task automatic wait_all_done();
    do @(negedge clk_i);
    while (value_q.size() != 0 || in_valid_i || inverse_due_q.size() != 0);
  endtask

  // clock
  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // cycle counter and timeout
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results pending", cycle_count,
               inverse_due_q.size());
      $display("status: fail");
      $finish;
    end
  end

  // request driver, predicts each request as it is taken
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else begin
      keep_offer = in_valid_i;
      if (in_valid_i && !in_stall_o) begin
        inverse_due_q.push_back(predict_inverse(value_i, modulus_model));
        keep_offer = 1'b0;
      end
      if (!keep_offer) begin
        if (value_q.size() != 0 && $urandom_range(0, 99) >= sender_idle_pct) begin
          value_i <= value_q.pop_front();
          in_valid_i <= 1'b1;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // result monitor and receiver stall
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        if (inverse_due_q.size() == 0) begin
          report_mismatch($sformatf("result with no request pending: inverse %0d gcd %0d",
                                    inverse_o, gcd_o));
        end else begin
          seen_due = inverse_due_q.pop_front();
          if (inverse_o !== seen_due.inverse)
            report_mismatch($sformatf("inverse of %0d mod %0d: got %0d expected %0d",
                                      seen_due.operand, seen_due.modulus,
                                      inverse_o, seen_due.inverse));
          if (gcd_o !== seen_due.gcd)
            report_mismatch($sformatf("gcd of %0d and %0d: got %0d expected %0d",
                                      seen_due.operand, seen_due.modulus,
                                      gcd_o, seen_due.gcd));
        end
      end
      out_stall_i <= recv_hold || ($urandom_range(0, 99) < recv_stall_pct);
    end
  end

  // long receiver hold-off so the core backs up and stalls its input
  initial begin
    wait (hold_start);
    recv_hold = 1'b1;
    repeat (HOLD_CYCLES) @(negedge clk_i);
    recv_hold = 1'b0;
  end

  // request sequence
  initial begin
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // reset modulus: zero, one, around m and its multiples, full-scale
    value_q = '{31'd0, 31'd1, 31'd2, 31'd1000000006, 31'd1000000007,
                31'd1000000008, 31'd2000000014, VAL_MAX};
    wait_all_done();

    // largest prime modulus, operand equal to it and top bit alone
    write_modulus(VAL_MAX);
    value_q = '{31'd0, 31'd1, VAL_MAX, VAL_MAX - 31'd1, 31'h4000_0000};
    wait_all_done();

    // smallest modulus
    write_modulus(31'd2);
    value_q = '{31'd0, 31'd1, 31'd2, 31'd3};
    wait_all_done();

    // composite modulus, operands with a common factor
    write_modulus(31'd12);
    value_q = '{31'd4, 31'd6, 31'd5, 31'd7, 31'd11};
    wait_all_done();

    // consecutive fibonacci numbers take the most euclid steps
    write_modulus(31'd1836311903);
    value_q = '{31'd1134903170, 31'h5555_5555};
    wait_all_done();

    // random phases across idle patterns and moduli
    for (int unsigned p = 0; p < RANDOM_PHASES; p++) begin
      case (p % 4)
        0: begin sender_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin sender_idle_pct = 83; recv_stall_pct = 0;  end
        2: begin sender_idle_pct = 0;  recv_stall_pct = 83; end
        default: begin sender_idle_pct = 33; recv_stall_pct = 33; end
      endcase
      phase_modulus = pick_modulus(p);
      write_modulus(phase_modulus);
      for (int unsigned n = 0; n < PHASE_REQUESTS; n++)
        value_q.push_back(pick_value(phase_modulus));
      wait_all_done();
    end

    // backpressure: sender keeps offering while the receiver holds off
    sender_idle_pct = 0;
    recv_stall_pct = 0;
    write_modulus(31'd97);
    for (int unsigned n = 0; n < 12; n++)
      value_q.push_back(pick_value(31'd97));
    hold_start = 1'b1;
    wait_all_done();

    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+hdl
hdl/mie_pkg.sv
hdl/mie_sequencer.sv
hdl/mie_datapath.sv
hdl/modular_inverse_ext_euclid_core.sv
sim/modular_inverse_ext_euclid_core_tb.sv
